// ===== hw/rtl/csfw_pkg.sv =====
// ----------------------------------------------------------------------------
// csfw_pkg: shared types and codes for the counting semaphore
// Beat layouts of the request and result channels, status codes and widths.
// ----------------------------------------------------------------------------
package csfw_pkg;

  localparam int TASK_W  = 6;
  localparam int COUNT_W = 16;
  localparam int INIT_W  = 15;

  // Operation codes
  localparam logic [1:0] OP_WAIT     = 2'd0;
  localparam logic [1:0] OP_TRY_WAIT = 2'd1;
  localparam logic [1:0] OP_POST     = 2'd2;

  // Status codes
  localparam logic [2:0] ST_GRANTED = 3'd0;
  localparam logic [2:0] ST_REFUSED = 3'd1;
  localparam logic [2:0] ST_BLOCKED = 3'd2;
  localparam logic [2:0] ST_POSTED  = 3'd3;
  localparam logic [2:0] ST_ERROR   = 3'd4;

  localparam logic signed [COUNT_W-1:0] COUNT_MAX = 16'sh7FFF;
  localparam logic signed [COUNT_W-1:0] COUNT_MIN = 16'sh8000;

  typedef struct packed {
    logic [1:0]        operation;
    logic [TASK_W-1:0] task_id;
  } in_item_t;

  typedef struct packed {
    logic [2:0]                status;
    logic                      wake_valid;
    logic [TASK_W-1:0]         wake_task;
    logic signed [COUNT_W-1:0] count_now;
  } out_item_t;

  // Requests from the control path to the waiter queue
  typedef struct packed {
    logic              push;
    logic              pop;
    logic [TASK_W-1:0] push_task;
  } queue_ctl_t;

  // Queue status seen by the control path
  typedef struct packed {
    logic              full;
    logic              empty;
    logic [TASK_W-1:0] head_task;
  } queue_stat_t;

endpackage

// ===== hw/rtl/counting_semaphore_fifo_wait_core.sv =====
// ----------------------------------------------------------------------------
// counting_semaphore_fifo_wait_core: counting semaphore with a waiter FIFO
// Request beats carry an operation and a task id; each one yields one
// result beat with status, the woken task (if any) and the new count.
// ----------------------------------------------------------------------------
// Usage:
//   in_valid/in_stall/in_data carry request beats (wait, try wait, post).
//   out_valid/out_stall/out_data carry one result beat per request, in order.
//   cfg_valid/cfg_ready/cfg_data load the count; write it only while idle.
// Timing:
//   A request beat lands in an input register, is resolved in a single pass
//   against the count and the waiter queue, and its result is written to the
//   output register once out_stall lets it advance. One request is taken every
//   cycle while out_stall is not holding a result; the count is updated in a
//   single pass, and the queue memory has a single write and read port, whose
//   read is addressed by the next head pointer.
// Reset:
//   Count, queue pointers and fill return to zero; queue contents are left
//   as they are and are only used after being written.
// Stall:
//   While out_stall holds a result, the pending request stays in the input
//   register and in_stall is raised; nothing is dropped.
// ----------------------------------------------------------------------------
module counting_semaphore_fifo_wait_core #(
  parameter int MAX_TASKS = 64
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  csfw_pkg::in_item_t             in_data,
  output logic                           out_valid,
  input  logic                           out_stall,
  output csfw_pkg::out_item_t            out_data,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [csfw_pkg::INIT_W-1:0]    cfg_data
);
  import csfw_pkg::*;

  logic        in_valid_r;
  in_item_t    in_item_r;
  logic        out_valid_r;
  out_item_t   out_item_r;
  out_item_t   res;
  logic signed [COUNT_W-1:0] cnt_r, cnt_nxt;
  logic        advance;
  logic        in_take;
  queue_ctl_t  q_ctl;
  queue_stat_t q_stat;

  csfw_wait_queue #(
    .MAX_TASKS(MAX_TASKS)
  ) u_queue (
    .clk  (clk),
    .rst_n(rst_n),
    .ctl  (q_ctl),
    .stat (q_stat)
  );

  assign advance   = in_valid_r && (!out_valid_r || !out_stall);
  assign in_stall  = in_valid_r && !advance;
  assign in_take   = in_valid && !in_stall;
  assign cfg_ready = !in_valid_r;

  always_comb begin
    res            = '0;
    res.status     = ST_ERROR;
    cnt_nxt        = cnt_r;
    q_ctl          = '0;
    q_ctl.push_task = in_item_r.task_id;
    if (advance) begin
      case (in_item_r.operation)
        OP_WAIT: begin
          if (cnt_r > 0) begin
            cnt_nxt    = cnt_r - 16'sd1;
            res.status = ST_GRANTED;
          end else if (!q_stat.full && (cnt_r != COUNT_MIN)) begin
            cnt_nxt    = cnt_r - 16'sd1;
            q_ctl.push = 1'b1;
            res.status = ST_BLOCKED;
          end
        end
        OP_TRY_WAIT: begin
          if (cnt_r > 0) begin
            cnt_nxt    = cnt_r - 16'sd1;
            res.status = ST_GRANTED;
          end else begin
            res.status = ST_REFUSED;
          end
        end
        OP_POST: begin
          if (cnt_r != COUNT_MAX) begin
            cnt_nxt    = cnt_r + 16'sd1;
            res.status = ST_POSTED;
            if (!q_stat.empty) begin
              q_ctl.pop      = 1'b1;
              res.wake_valid = 1'b1;
              res.wake_task  = q_stat.head_task;
            end
          end
        end
        default: begin
          res.status = ST_ERROR;
        end
      endcase
    end
    if (cfg_valid && cfg_ready) begin
      cnt_nxt = {1'b0, cfg_data};
    end
    res.count_now = cnt_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      cnt_r       <= '0;
    end else begin
      cnt_r <= cnt_nxt;
      if (in_take) begin
        in_valid_r <= 1'b1;
      end else if (advance) begin
        in_valid_r <= 1'b0;
      end
      if (advance) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      in_item_r <= in_data;
    end
    if (advance) begin
      out_item_r <= res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_item_r;

endmodule

// ===== hw/rtl/csfw_wait_queue.sv =====
// ----------------------------------------------------------------------------
// csfw_wait_queue: FIFO of blocked task ids
// Circular buffer in a memory with a registered read of the oldest entry,
// kept current with a write-to-read bypass.
// ----------------------------------------------------------------------------
module csfw_wait_queue #(
  parameter int MAX_TASKS = 64
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  csfw_pkg::queue_ctl_t ctl,
  output csfw_pkg::queue_stat_t stat
);
  import csfw_pkg::*;

  localparam int PTR_W  = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
  localparam int FILL_W = $clog2(MAX_TASKS + 1);
  localparam logic [PTR_W-1:0]  PTR_LAST = PTR_W'(MAX_TASKS - 1);
  localparam logic [FILL_W-1:0] FILL_MAX = FILL_W'(MAX_TASKS);

  logic [TASK_W-1:0] mem [MAX_TASKS];

  logic [PTR_W-1:0]  head_r, head_nxt;
  logic [PTR_W-1:0]  tail_r, tail_nxt;
  logic [FILL_W-1:0] fill_r, fill_nxt;
  logic [TASK_W-1:0] head_task_r;

  always_comb begin
    head_nxt = head_r;
    tail_nxt = tail_r;
    fill_nxt = fill_r;
    if (ctl.pop) begin
      head_nxt = (head_r == PTR_LAST) ? '0 : head_r + 1'b1;
      fill_nxt = fill_nxt - 1'b1;
    end
    if (ctl.push) begin
      tail_nxt = (tail_r == PTR_LAST) ? '0 : tail_r + 1'b1;
      fill_nxt = fill_nxt + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r <= '0;
      tail_r <= '0;
      fill_r <= '0;
    end else begin
      head_r <= head_nxt;
      tail_r <= tail_nxt;
      fill_r <= fill_nxt;
    end
  end

  // The read always looks one step ahead at the next head, so the oldest
  // waiter is ready in a register when a post arrives. A push into the slot
  // being read is forwarded, as the array still holds the old contents.
  always_ff @(posedge clk) begin
    if (ctl.push) begin
      mem[tail_r] <= ctl.push_task;
    end
    if (ctl.push && (tail_r == head_nxt)) begin
      head_task_r <= ctl.push_task;
    end else begin
      head_task_r <= mem[head_nxt];
    end
  end

  assign stat.full      = (fill_r == FILL_MAX);
  assign stat.empty     = (fill_r == '0);
  assign stat.head_task = head_task_r;

endmodule

// ===== hw/rtl/csfw_checker.sv =====
// ----------------------------------------------------------------------------
// csfw_checker: port-level checks for the counting semaphore
// Watches the request and result channels over time and is bound to the top level.
// ----------------------------------------------------------------------------
module csfw_checker (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        in_valid,
  input logic                        in_stall,
  input logic                        out_valid,
  input logic                        out_stall,
  input csfw_pkg::out_item_t         out_data
);
  import csfw_pkg::*;

  // A held result beat must keep its contents.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("result beat changed while stalled");

  // Only a successful post can wake a waiter.
  a_wake_post: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.wake_valid |-> out_data.status == ST_POSTED)
    else $error("wake reported without a post");

  // Without a wake the task field reads zero.
  a_wake_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.wake_valid |-> out_data.wake_task == '0)
    else $error("wake task set without a wake");

  // A request accepted while no result is valid must yield a result beat.
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && !out_valid |-> ##2 out_valid)
    else $error("result beat missing after request");

  // Nothing comes out of reset as a result.
  a_reset: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind counting_semaphore_fifo_wait_core csfw_checker u_csfw_checker (
  .clk      (clk),
  .rst_n    (rst_n),
  .in_valid (in_valid),
  .in_stall (in_stall),
  .out_valid(out_valid),
  .out_stall(out_stall),
  .out_data (out_data)
);
